>>> src/pgcr_pkg.sv
`timescale 1ns / 1ps

package pgcr_pkg;

  // Frame geometry
  localparam int FRAME_PIXELS = 4096;
  localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int COUNT_W      = $clog2(FRAME_PIXELS + 1);

  // Corrected values at or above this limit are marked saturated
  localparam int SAT_LIMIT = 32767;

  localparam logic signed [15:0] MIN_RESET = 16'sd32766;

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_BIAS = 2'd0;
  localparam logic [1:0] REG_PEDESTAL   = 2'd1;
  localparam logic [1:0] REG_HOT_CODE   = 2'd2;
  localparam logic [1:0] REG_SKIP_CODE  = 2'd3;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_SAT    = 2'd1,
    KIND_TAG    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] value;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } store_wr_t;

endpackage

>>> src/pixel_gain_correct_rebase.sv
`timescale 1ns / 1ps

// Pixel gain correction with rebasing of each frame to a non-negative range.
//
// Input channel (in_valid / in_stall): action 0 loads pixel_in with its Q8.16
// gain into the frame store, action 1 asks for the next corrected pixel. A
// transfer takes place on a rising edge with in_valid high and in_stall low.
// Loads beyond a full frame and emits before the frame is full are taken and
// dropped without a result.
// Output channel (out_valid / out_stall): pixel_out, frame_end, new_offset.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
// write only while the block is idle.
// Throughput: one item at a time. A load runs through offset subtract,
// multiply and write into the frame memory; an emit runs through memory
// read and then result into the output register. The next item is taken
// while a result waits in the output register; an emit that finds it still
// full holds there until the receiver drops out_stall.
// Reset clears the counters and out_valid, and sets the running minimum and
// the configuration to their reset values; the frame memory is not cleared
// (it is always fully loaded first).

module pixel_gain_correct_rebase import pgcr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [15:0] pixel_in,
  input  logic [23:0]        gain,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pixel_out,
  output logic               frame_end,
  output logic [15:0]        new_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [14:0]        pixel_bias;
  logic signed [15:0] pedestal;
  logic signed [15:0] hot_code;
  logic signed [15:0] skip_code;

  // frame bookkeeping
  logic [COUNT_W-1:0] load_count;
  logic [ADDR_W-1:0]  emit_index;
  logic signed [15:0] running_min;
  logic [ADDR_W-1:0]  load_addr;
  logic [15:0]        emit_offset;
  logic               emit_last;

  logic        in_xfer;
  logic        frame_full;
  logic        load_go;
  logic        emit_go;
  logic        out_free;
  logic [15:0] offset_now;

  logic      corr_done;
  entry_t    corr_entry;
  store_wr_t store_wr;
  entry_t    rd_entry;

  logic signed [17:0] sum;
  logic signed [15:0] result;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign frame_full = (load_count == COUNT_W'(FRAME_PIXELS));
  assign load_go    = in_xfer && !action && !frame_full;
  assign emit_go    = in_xfer && action && frame_full;
  assign out_free   = !out_valid || !out_stall;

  // Rebase offset: the magnitude of a negative minimum, else nothing
  assign offset_now = running_min[15] ? (~running_min + 16'd1) : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bias <= '0;
      pedestal   <= '0;
      hot_code   <= 16'sd32767;
      skip_code  <= -16'sd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIXEL_BIAS: pixel_bias <= cfg_data[14:0];
        REG_PEDESTAL:   pedestal   <= cfg_data;
        REG_HOT_CODE:   hot_code   <= cfg_data;
        REG_SKIP_CODE:  skip_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  pgcr_correct u_correct (
    .clk        (clk),
    .rst        (rst),
    .start      (load_go),
    .pixel      (pixel_in),
    .gain       (gain),
    .pixel_bias (pixel_bias),
    .pedestal   (pedestal),
    .hot_code   (hot_code),
    .skip_code  (skip_code),
    .done       (corr_done),
    .entry      (corr_entry)
  );

  assign store_wr.en   = corr_done;
  assign store_wr.addr = load_addr;
  assign store_wr.data = corr_entry;

  pgcr_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_en   (emit_go),
    .rd_addr (emit_index),
    .rd_data (rd_entry)
  );

  // Add the offset to a normal entry and cap at the top of the range
  assign sum = 18'(signed'({{2{rd_entry.value[15]}}, rd_entry.value}))
             + 18'(signed'({2'b00, emit_offset}));

  always_comb begin
    case (rd_entry.kind)
      KIND_SAT: result = skip_code;
      KIND_TAG: result = rd_entry.value;
      default:  result = (sum > 18'sd32767) ? 16'sd32767 : sum[15:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      load_count  <= '0;
      emit_index  <= '0;
      running_min <= MIN_RESET;
    end else begin
      // fill the output register when the emit read is back and it is free;
      // otherwise drop the held result once the receiver takes it
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (load_go) begin
            load_addr  <= load_count[ADDR_W-1:0];
            load_count <= load_count + 1'b1;
            state      <= S_LOAD;
          end else if (emit_go) begin
            emit_offset <= offset_now;
            emit_last   <= (emit_index == ADDR_W'(FRAME_PIXELS - 1));
            if (emit_index == ADDR_W'(FRAME_PIXELS - 1)) begin
              // close the frame and start the next one
              load_count  <= '0;
              emit_index  <= '0;
              running_min <= MIN_RESET;
            end else begin
              emit_index <= emit_index + 1'b1;
            end
            state <= S_EMIT;
          end
        end
        S_LOAD: begin
          if (corr_done) begin
            if (corr_entry.kind == KIND_NORMAL && corr_entry.value < running_min) begin
              running_min <= corr_entry.value;
            end
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          // hold the read data until the output register is free
          if (out_free) begin
            pixel_out  <= result;
            frame_end  <= emit_last;
            new_offset <= emit_offset;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The frame memory is written only by the load sequence
  assert property (@(posedge clk) disable iff (rst)
    store_wr.en |-> (state == S_LOAD))
    else $error("frame store written outside a load");

  // A result appears only from the emit state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result produced without an emit");

  // An emit is never taken on a partly loaded frame
  assert property (@(posedge clk) disable iff (rst)
    emit_go |-> (load_count == COUNT_W'(FRAME_PIXELS)))
    else $error("emit taken before the frame is full");

  // Rebase offset stays within the range of a 16-bit magnitude
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (new_offset <= 16'd32768))
    else $error("rebase offset out of range");
`endif

endmodule

>>> src/pgcr_store.sv
`timescale 1ns / 1ps

module pgcr_store import pgcr_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [FRAME_PIXELS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read; holds its data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/pgcr_correct.sv
`timescale 1ns / 1ps

module pgcr_correct import pgcr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] pixel,
  input  logic [23:0]        gain,
  input  logic [14:0]        pixel_bias,
  input  logic signed [15:0] pedestal,
  input  logic signed [15:0] hot_code,
  input  logic signed [15:0] skip_code,
  output logic               done,
  output entry_t             entry
);

  // stage 1: offsets removed
  logic               s1_valid;
  logic               s1_tag;
  logic signed [15:0] s1_pixel;
  logic signed [17:0] s1_diff;
  logic [23:0]        s1_gain;

  // stage 2: product
  logic               s2_valid;
  logic               s2_tag;
  logic signed [15:0] s2_pixel;
  logic signed [42:0] s2_prod;

  logic signed [42:0] rounded;
  logic signed [26:0] corr;
  logic               sat;
  logic               clamp_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_tag   <= (pixel == hot_code) || (pixel == skip_code);
      s1_pixel <= pixel;
      s1_diff  <= 18'(signed'({{2{pixel[15]}}, pixel}))
                - 18'(signed'({3'b000, pixel_bias}))
                - 18'(signed'({{2{pedestal[15]}}, pedestal}));
      s1_gain  <= gain;
    end
    if (s1_valid) begin
      s2_tag   <= s1_tag;
      s2_pixel <= s1_pixel;
      s2_prod  <= 43'(s1_diff * signed'({1'b0, s1_gain}));
    end
  end

  // Truncate toward zero: bias negative products before the arithmetic shift
  assign rounded   = s2_prod + (s2_prod[42] ? 43'sd65535 : 43'sd0);
  assign corr      = rounded[42:16];
  assign sat       = corr >= 27'(SAT_LIMIT);
  assign clamp_low = corr < -27'sd32768;

  always_comb begin
    if (s2_tag) begin
      entry.kind  = KIND_TAG;
      entry.value = s2_pixel;
    end else if (sat) begin
      entry.kind  = KIND_SAT;
      entry.value = '0;
    end else begin
      entry.kind  = KIND_NORMAL;
      entry.value = clamp_low ? -16'sd32768 : corr[15:0];
    end
  end

  assign done = s2_valid;

endmodule
